>>> rtl/tdpu_pkg.sv
// Shared types and constants for the compact-instruction data-processing unit.
// Used by tdpu_shifter, tdpu_exec and thumb_data_processing_unit.
package tdpu_pkg;

  // Instruction format masks and match patterns
  localparam logic [15:0] AddSubMask   = 16'hf800;
  localparam logic [15:0] AddSubMatch  = 16'h1800;
  localparam logic [15:0] ClassMask    = 16'he000;
  localparam logic [15:0] ShiftMatch   = 16'h0000;
  localparam logic [15:0] ImmMatch     = 16'h2000;
  localparam logic [15:0] RegOpMask    = 16'hfc00;
  localparam logic [15:0] AluMatch     = 16'h4000;
  localparam logic [15:0] HiRegMatch   = 16'h4400;
  localparam logic [3:0]  PcIndex      = 4'd15;

  // Decoded instruction format
  typedef enum logic [2:0] {
    FORM_SHIFT,
    FORM_ADDSUB,
    FORM_IMM,
    FORM_ALU,
    FORM_HIREG,
    FORM_NONE
  } tdpu_form_e;

  // Barrel shifter operations
  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_e;

  // Immediate-form operations
  typedef enum logic [1:0] {
    IMM_MOV = 2'd0,
    IMM_CMP = 2'd1,
    IMM_ADD = 2'd2,
    IMM_SUB = 2'd3
  } imm_op_e;

  // Register ALU operations
  typedef enum logic [3:0] {
    ALU_AND = 4'h0,
    ALU_EOR = 4'h1,
    ALU_LSL = 4'h2,
    ALU_LSR = 4'h3,
    ALU_ASR = 4'h4,
    ALU_ADC = 4'h5,
    ALU_SBC = 4'h6,
    ALU_ROR = 4'h7,
    ALU_TST = 4'h8,
    ALU_NEG = 4'h9,
    ALU_CMP = 4'ha,
    ALU_CMN = 4'hb,
    ALU_ORR = 4'hc,
    ALU_MUL = 4'hd,
    ALU_BIC = 4'he,
    ALU_MVN = 4'hf
  } alu_op_e;

  // High-register operations
  typedef enum logic [1:0] {
    HI_ADD = 2'd0,
    HI_CMP = 2'd1,
    HI_MOV = 2'd2,
    HI_BX  = 2'd3
  } hi_op_e;

  // One executed result
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  dest;
    logic        wr_en;
    logic [3:0]  flags;
    logic        pc_reload;
    logic        unsupported;
  } tdpu_result_t;

endpackage

>>> rtl/tdpu_shifter.sv
// Barrel shifter with carry out for LSL/LSR/ASR/ROR by an 8-bit amount.
// Depends on tdpu_pkg for the shift kind type.
module tdpu_shifter (
  input  tdpu_pkg::shift_kind_e kind_i,
  input  logic [31:0]           value_i,
  input  logic [7:0]            amount_i,
  input  logic                  carry_i,
  output logic [31:0]           value_o,
  output logic                  carry_o
);
  import tdpu_pkg::*;

  logic [4:0]         sh5;
  logic               big;
  logic               exact32;
  logic               sign;
  logic [32:0]        lsl_ext;
  logic [32:0]        lsr_ext;
  logic signed [32:0] asr_ext;
  logic [63:0]        ror_ext;

  assign sh5     = amount_i[4:0];
  assign big     = (amount_i[7:5] != 3'd0);
  assign exact32 = (amount_i == 8'd32);
  assign sign    = value_i[31];

  // Extended shifts keep the last bit shifted out next to the result
  assign lsl_ext = {1'b0, value_i} << sh5;
  assign lsr_ext = {value_i, 1'b0} >> sh5;
  assign asr_ext = $signed({value_i, 1'b0}) >>> sh5;
  assign ror_ext = {value_i, value_i} >> sh5;

  always_comb begin
    value_o = value_i;
    carry_o = carry_i;
    if (amount_i != 8'd0) begin
      unique case (kind_i)
        SHIFT_LSL: begin
          if (!big) begin
            value_o = lsl_ext[31:0];
            carry_o = lsl_ext[32];
          end else begin
            value_o = '0;
            carry_o = exact32 & value_i[0];
          end
        end
        SHIFT_LSR: begin
          if (!big) begin
            value_o = lsr_ext[32:1];
            carry_o = lsr_ext[0];
          end else begin
            value_o = '0;
            carry_o = exact32 & sign;
          end
        end
        SHIFT_ASR: begin
          if (!big) begin
            value_o = asr_ext[32:1];
            carry_o = asr_ext[0];
          end else begin
            value_o = {32{sign}};
            carry_o = sign;
          end
        end
        default: begin
          // ROR by a multiple of 32 keeps the value
          if (sh5 == 5'd0) begin
            value_o = value_i;
            carry_o = sign;
          end else begin
            value_o = ror_ext[31:0];
            carry_o = ror_ext[31];
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/tdpu_exec.sv
// Decode and execute of one data-processing instruction: shared adder,
// shifter, multiplier and logic ops. Depends on tdpu_pkg and tdpu_shifter.
module tdpu_exec (
  input  logic [15:0]            instruction_i,
  input  logic [31:0]            first_operand_i,
  input  logic [31:0]            second_operand_i,
  input  logic [31:0]            offset_operand_i,
  input  logic [3:0]             flags_in_i,
  output tdpu_pkg::tdpu_result_t result_o
);
  import tdpu_pkg::*;

  tdpu_form_e  form;
  alu_op_e     alu_op;
  imm_op_e     imm_op;
  hi_op_e      hi_op;
  logic [31:0] a;
  logic [31:0] b;
  logic        c_in;
  logic        v_in;

  // Shared adder
  logic [31:0] add_x;
  logic [31:0] add_y;
  logic        add_cin;
  logic [32:0] add_sum;
  logic        add_c;
  logic        add_v;

  // Shared shifter
  shift_kind_e sh_kind;
  logic [31:0] sh_val;
  logic [7:0]  sh_amt;
  logic [31:0] sh_res;
  logic        sh_c;

  logic [31:0] product;
  logic [31:0] addsub_opnd;
  logic [31:0] imm8;
  logic [31:0] res;
  logic        set_nz;
  logic        c_out;
  logic        v_out;

  assign a      = first_operand_i;
  assign b      = second_operand_i;
  assign c_in   = flags_in_i[1];
  assign v_in   = flags_in_i[0];
  assign alu_op = alu_op_e'(instruction_i[9:6]);
  assign imm_op = imm_op_e'(instruction_i[12:11]);
  assign hi_op  = hi_op_e'(instruction_i[9:8]);
  assign imm8   = {24'd0, instruction_i[7:0]};
  assign addsub_opnd = instruction_i[10] ? {29'd0, instruction_i[8:6]} : offset_operand_i;

  // Format decode, in priority order
  always_comb begin
    if ((instruction_i & AddSubMask) == AddSubMatch) begin
      form = FORM_ADDSUB;
    end else if ((instruction_i & ClassMask) == ShiftMatch) begin
      form = FORM_SHIFT;
    end else if ((instruction_i & ClassMask) == ImmMatch) begin
      form = FORM_IMM;
    end else if ((instruction_i & RegOpMask) == AluMatch) begin
      form = FORM_ALU;
    end else if ((instruction_i & RegOpMask) == HiRegMatch) begin
      form = FORM_HIREG;
    end else begin
      form = FORM_NONE;
    end
  end

  // Adder operand select
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = 1'b0;
    unique case (form)
      FORM_ADDSUB: begin
        add_x   = b;
        add_y   = instruction_i[9] ? ~addsub_opnd : addsub_opnd;
        add_cin = instruction_i[9];
      end
      FORM_IMM: begin
        add_y   = (imm_op == IMM_ADD) ? imm8 : ~imm8;
        add_cin = (imm_op != IMM_ADD);
      end
      FORM_ALU: begin
        unique case (alu_op)
          ALU_ADC: add_cin = c_in;
          ALU_SBC: begin
            add_y   = ~b;
            add_cin = c_in;
          end
          ALU_NEG: begin
            add_x   = '0;
            add_y   = ~b;
            add_cin = 1'b1;
          end
          ALU_CMP: begin
            add_y   = ~b;
            add_cin = 1'b1;
          end
          default: add_cin = 1'b0;
        endcase
      end
      FORM_HIREG: begin
        add_y   = (hi_op == HI_CMP) ? ~b : b;
        add_cin = (hi_op == HI_CMP);
      end
      default: add_cin = 1'b0;
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
  assign add_c   = add_sum[32];
  assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_sum[31]);

  // Shifter operand select
  always_comb begin
    if (form == FORM_SHIFT) begin
      sh_kind = shift_kind_e'(instruction_i[12:11]);
      sh_val  = b;
      if (instruction_i[12:11] != 2'd0 && instruction_i[10:6] == 5'd0) begin
        sh_amt = 8'd32;
      end else begin
        sh_amt = {3'd0, instruction_i[10:6]};
      end
    end else begin
      sh_val = a;
      sh_amt = b[7:0];
      unique case (alu_op)
        ALU_LSR: sh_kind = SHIFT_LSR;
        ALU_ASR: sh_kind = SHIFT_ASR;
        ALU_ROR: sh_kind = SHIFT_ROR;
        default: sh_kind = SHIFT_LSL;
      endcase
    end
  end

  tdpu_shifter u_shifter (
    .kind_i   (sh_kind),
    .value_i  (sh_val),
    .amount_i (sh_amt),
    .carry_i  (c_in),
    .value_o  (sh_res),
    .carry_o  (sh_c)
  );

  assign product = a * b;

  // Result, flags and write-back control
  always_comb begin
    res                  = '0;
    set_nz               = 1'b0;
    c_out                = c_in;
    v_out                = v_in;
    result_o.dest        = '0;
    result_o.wr_en       = 1'b0;
    result_o.pc_reload   = 1'b0;
    result_o.unsupported = 1'b0;
    unique case (form)
      FORM_ADDSUB: begin
        res            = add_sum[31:0];
        c_out          = add_c;
        v_out          = add_v;
        set_nz         = 1'b1;
        result_o.dest  = {1'b0, instruction_i[2:0]};
        result_o.wr_en = 1'b1;
      end
      FORM_SHIFT: begin
        res            = sh_res;
        c_out          = sh_c;
        set_nz         = 1'b1;
        result_o.dest  = {1'b0, instruction_i[2:0]};
        result_o.wr_en = 1'b1;
      end
      FORM_IMM: begin
        set_nz         = 1'b1;
        result_o.dest  = {1'b0, instruction_i[10:8]};
        result_o.wr_en = (imm_op != IMM_CMP);
        if (imm_op == IMM_MOV) begin
          res = imm8;
        end else begin
          res   = add_sum[31:0];
          c_out = add_c;
          v_out = add_v;
        end
      end
      FORM_ALU: begin
        set_nz         = 1'b1;
        result_o.dest  = {1'b0, instruction_i[2:0]};
        result_o.wr_en = !(alu_op == ALU_TST || alu_op == ALU_CMP || alu_op == ALU_CMN);
        unique case (alu_op) inside
          ALU_AND, ALU_TST: res = a & b;
          ALU_EOR:          res = a ^ b;
          ALU_ORR:          res = a | b;
          ALU_BIC:          res = a & ~b;
          ALU_MVN:          res = ~b;
          ALU_MUL:          res = product;
          ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
            res   = sh_res;
            c_out = sh_c;
          end
          default: begin
            // ADC, SBC, NEG, CMP, CMN
            res   = add_sum[31:0];
            c_out = add_c;
            v_out = add_v;
          end
        endcase
      end
      FORM_HIREG: begin
        result_o.dest = {instruction_i[7], instruction_i[2:0]};
        unique case (hi_op)
          HI_ADD: begin
            res            = add_sum[31:0];
            result_o.wr_en = 1'b1;
          end
          HI_CMP: begin
            res    = add_sum[31:0];
            c_out  = add_c;
            v_out  = add_v;
            set_nz = 1'b1;
          end
          HI_MOV: begin
            res            = b;
            result_o.wr_en = 1'b1;
          end
          default: begin
            // branch exchange is not handled here
            result_o.dest        = '0;
            result_o.unsupported = 1'b1;
          end
        endcase
        // A write to the program counter forces alignment and a refill
        if (result_o.wr_en && result_o.dest == PcIndex) begin
          res[0]             = 1'b0;
          result_o.pc_reload = 1'b1;
        end
      end
      default: result_o.unsupported = 1'b1;
    endcase
    result_o.value = res;
    result_o.flags = {set_nz ? res[31] : flags_in_i[3],
                      set_nz ? (res == 32'd0) : flags_in_i[2],
                      c_out, v_out};
  end

endmodule

>>> rtl/thumb_data_processing_unit.sv
// Execute unit for one 16-bit data-processing instruction per cycle.
// Depends on tdpu_pkg and tdpu_exec.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries the instruction halfword,
//   the operand register values and the current NZCV flags. Output channel
//   (out_valid_o / out_stall_i) carries the result value, destination index,
//   write enable, new flags, program-counter reload and unsupported marks.
//   A transfer happens at a rising edge where valid is high and stall low.
//   The input register captures at the transfer edge and the result register
//   captures the executed result when the output stage is free; the result
//   is then on the output ports until it transfers.
//   Throughput: one instruction per cycle while out_stall_i is low; the
//   critical path is the 32x32 low-half multiplier or the 32-bit adder
//   with the zero-flag reduction. Exactly one result leaves for each
//   instruction taken. Reset (rst_ni low, asynchronous) empties both stages;
//   no result is pending afterwards and stall is low.
//   When the receiver stalls, the result register holds its transfer; the
//   input register still fills, and only when both are full does
//   in_stall_o rise. in_stall_o depends combinationally on out_stall_i.
module thumb_data_processing_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] instruction_i,
  input  logic [31:0] first_operand_i,
  input  logic [31:0] second_operand_i,
  input  logic [31:0] offset_operand_i,
  input  logic [3:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic [3:0]  dest_index_o,
  output logic        write_enable_o,
  output logic [3:0]  flags_out_o,
  output logic        pc_reload_o,
  output logic        unsupported_o
);
  import tdpu_pkg::*;

  logic         s1_valid_q;
  logic [15:0]  instr_q;
  logic [31:0]  op_a_q;
  logic [31:0]  op_b_q;
  logic [31:0]  op_off_q;
  logic [3:0]   flags_q;
  logic         out_valid_q;
  tdpu_result_t result_q;
  tdpu_result_t result_d;
  logic         out_ready;
  logic         in_xfer;

  // Flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || out_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      instr_q  <= instruction_i;
      op_a_q   <= first_operand_i;
      op_b_q   <= second_operand_i;
      op_off_q <= offset_operand_i;
      flags_q  <= flags_in_i;
    end
  end

  tdpu_exec u_exec (
    .instruction_i    (instr_q),
    .first_operand_i  (op_a_q),
    .second_operand_i (op_b_q),
    .offset_operand_i (op_off_q),
    .flags_in_i       (flags_q),
    .result_o         (result_d)
  );

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q.value;
  assign dest_index_o   = result_q.dest;
  assign write_enable_o = result_q.wr_en;
  assign flags_out_o    = result_q.flags;
  assign pc_reload_o    = result_q.pc_reload;
  assign unsupported_o  = result_q.unsupported;

`ifndef SYNTHESIS
  // An unsupported instruction never writes or reloads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |-> !write_enable_o && !pc_reload_o)
    else $error("unsupported result writes a register");

  // A reload only follows an aligned write to the program counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pc_reload_o |->
      write_enable_o && dest_index_o == PcIndex && !result_value_o[0])
    else $error("bad program counter reload");

  // A taken item is held in the input stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("input transfer lost");

  // A full input stage with a free output stage moves forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_ready |=> out_valid_q)
    else $error("result not registered");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for thumb_data_processing_unit: directed and random
// instruction streams, with every result compared against an in-bench predictor.
// Depends on tdpu_pkg and the RTL of thumb_data_processing_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpu_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] instruction_i = '0;
  logic [31:0] first_operand_i = '0;
  logic [31:0] second_operand_i = '0;
  logic [31:0] offset_operand_i = '0;
  logic [3:0]  flags_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic [3:0]  dest_index_o;
  logic        write_enable_o;
  logic [3:0]  flags_out_o;
  logic        pc_reload_o;
  logic        unsupported_o;

  tdpu_result_t pending_results[$];
  logic [15:0]  pending_instrs[$];
  int           mismatch_count = 0;
  int           results_checked = 0;
  int           instrs_issued = 0;
  int           hold_left = 0;
  bit           quiet = 1'b0;

  thumb_data_processing_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .instruction_i    (instruction_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .offset_operand_i (offset_operand_i),
    .flags_in_i       (flags_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_o   (result_value_o),
    .dest_index_o     (dest_index_o),
    .write_enable_o   (write_enable_o),
    .flags_out_o      (flags_out_o),
    .pc_reload_o      (pc_reload_o),
    .unsupported_o    (unsupported_o)
  );

  always #10 clk_i = ~clk_i;

  // Instruction encoders
  function automatic logic [15:0] enc_shift(shift_kind_e kind, logic [4:0] amt,
                                            logic [2:0] rs, logic [2:0] rd);
    return {ShiftMatch[15:13], kind, amt, rs, rd};
  endfunction

  function automatic logic [15:0] enc_addsub(logic is_imm, logic is_sub, logic [2:0] rn,
                                             logic [2:0] rs, logic [2:0] rd);
    return {AddSubMatch[15:11], is_imm, is_sub, rn, rs, rd};
  endfunction

  function automatic logic [15:0] enc_imm(imm_op_e op, logic [2:0] rd, logic [7:0] imm);
    return {ImmMatch[15:13], op, rd, imm};
  endfunction

  function automatic logic [15:0] enc_alu(alu_op_e op, logic [2:0] rs, logic [2:0] rd);
    return {AluMatch[15:10], op, rs, rd};
  endfunction

  function automatic logic [15:0] enc_hi(hi_op_e op, logic h1, logic h2,
                                         logic [2:0] rs, logic [2:0] rd);
    return {HiRegMatch[15:10], op, h1, h2, rs, rd};
  endfunction

  // Adder: returns {carry, overflow, sum}
  function automatic logic [33:0] add_cv(logic [31:0] x, logic [31:0] y, logic cin);
    logic [32:0] s;
    logic        ov;
    s  = {1'b0, x} + {1'b0, y} + {32'd0, cin};
    ov = ~(x[31] ^ y[31]) & (x[31] ^ s[31]);
    return {s[32], ov, s[31:0]};
  endfunction

  // Barrel shifter: returns {carry out, value}; amt is the full 8-bit amount
  function automatic logic [32:0] barrel(shift_kind_e kind, logic [31:0] val,
                                         logic [7:0] amt, logic cin);
    logic [31:0] r;
    logic [4:0]  k;
    logic        sg;
    sg = val[31];
    if (amt == 8'd0) return {cin, val};
    case (kind)
      SHIFT_LSL: begin
        if (amt < 8'd32) return {val[32 - amt], val << amt};
        return {(amt == 8'd32) ? val[0] : 1'b0, 32'd0};
      end
      SHIFT_LSR: begin
        if (amt < 8'd32) return {val[amt - 1], val >> amt};
        return {(amt == 8'd32) ? sg : 1'b0, 32'd0};
      end
      SHIFT_ASR: begin
        if (amt < 8'd32) begin
          r = $signed(val) >>> amt;
          return {val[amt - 1], r};
        end
        return {sg, {32{sg}}};
      end
      default: begin
        k = amt[4:0];
        if (k == 5'd0) return {sg, val};
        r = (val >> k) | (val << (32 - k));
        return {r[31], r};
      end
    endcase
  endfunction

  // Predicted outcome of executing one instruction
  function automatic tdpu_result_t execute_instr(logic [15:0] ins, logic [31:0] a,
                                                 logic [31:0] b, logic [31:0] off,
                                                 logic [3:0] fl);
    tdpu_result_t exp;
    logic [31:0]  res, opnd, imm;
    logic [7:0]   amt;
    logic [3:0]   rd;
    logic         n, z, c, v, we, pcr, uns, setnz;
    shift_kind_e  kind;
    imm_op_e      iop;
    alu_op_e      aop;
    hi_op_e       hop;
    res = '0; rd = '0; we = 1'b0; pcr = 1'b0; uns = 1'b0; setnz = 1'b0;
    {n, z, c, v} = fl;
    if ((ins & AddSubMask) == AddSubMatch) begin
      opnd = ins[10] ? {29'd0, ins[8:6]} : off;
      if (ins[9]) {c, v, res} = add_cv(b, ~opnd, 1'b1);
      else {c, v, res} = add_cv(b, opnd, 1'b0);
      rd = {1'b0, ins[2:0]}; we = 1'b1; setnz = 1'b1;
    end else if ((ins & ClassMask) == ShiftMatch) begin
      kind = shift_kind_e'(ins[12:11]);
      amt  = {3'd0, ins[10:6]};
      // LSR/ASR by zero encode a shift by 32
      if (kind != SHIFT_LSL && amt == 8'd0) amt = 8'd32;
      {c, res} = barrel(kind, b, amt, c);
      rd = {1'b0, ins[2:0]}; we = 1'b1; setnz = 1'b1;
    end else if ((ins & ClassMask) == ImmMatch) begin
      iop = imm_op_e'(ins[12:11]);
      imm = {24'd0, ins[7:0]};
      rd  = {1'b0, ins[10:8]}; setnz = 1'b1; we = (iop != IMM_CMP);
      case (iop)
        IMM_MOV: res = imm;
        IMM_ADD: {c, v, res} = add_cv(a, imm, 1'b0);
        default: {c, v, res} = add_cv(a, ~imm, 1'b1);
      endcase
    end else if ((ins & RegOpMask) == AluMatch) begin
      aop = alu_op_e'(ins[9:6]);
      rd  = {1'b0, ins[2:0]}; setnz = 1'b1;
      we  = !(aop == ALU_TST || aop == ALU_CMP || aop == ALU_CMN);
      case (aop) inside
        ALU_AND, ALU_TST: res = a & b;
        ALU_EOR: res = a ^ b;
        ALU_LSL: {c, res} = barrel(SHIFT_LSL, a, b[7:0], c);
        ALU_LSR: {c, res} = barrel(SHIFT_LSR, a, b[7:0], c);
        ALU_ASR: {c, res} = barrel(SHIFT_ASR, a, b[7:0], c);
        ALU_ROR: {c, res} = barrel(SHIFT_ROR, a, b[7:0], c);
        ALU_ADC: {c, v, res} = add_cv(a, b, c);
        ALU_SBC: {c, v, res} = add_cv(a, ~b, c);
        ALU_NEG: {c, v, res} = add_cv(32'd0, ~b, 1'b1);
        ALU_CMP: {c, v, res} = add_cv(a, ~b, 1'b1);
        ALU_CMN: {c, v, res} = add_cv(a, b, 1'b0);
        ALU_ORR: res = a | b;
        ALU_MUL: res = a * b;
        ALU_BIC: res = a & ~b;
        default: res = ~b;
      endcase
    end else if ((ins & RegOpMask) == HiRegMatch) begin
      hop = hi_op_e'(ins[9:8]);
      rd  = {ins[7], ins[2:0]};
      case (hop)
        HI_ADD: begin
          res = a + b; we = 1'b1;
        end
        HI_CMP: begin
          {c, v, res} = add_cv(a, ~b, 1'b1); setnz = 1'b1;
        end
        HI_MOV: begin
          res = b; we = 1'b1;
        end
        default: begin
          uns = 1'b1; rd = '0;
        end
      endcase
      // writing r15 forces halfword alignment and a refill
      if (we && rd == PcIndex) begin
        res[0] = 1'b0; pcr = 1'b1;
      end
    end else begin
      uns = 1'b1;
    end
    if (setnz) begin
      n = res[31];
      z = (res == 32'd0);
    end
    exp.value       = res;
    exp.dest        = rd;
    exp.wr_en       = we;
    exp.flags       = {n, z, c, v};
    exp.pc_reload   = pcr;
    exp.unsupported = uns;
    return exp;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Send one instruction; returns on the edge of its transfer, valid left high
  task automatic issue_instr(input logic [15:0] ins, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] off,
                             input logic [3:0] fl);
    bit took;
    while (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    instruction_i    <= ins;
    first_operand_i  <= a;
    second_operand_i <= b;
    offset_operand_i <= off;
    flags_in_i       <= fl;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    pending_results.push_back(execute_instr(ins, a, b, off, fl));
    pending_instrs.push_back(ins);
    instrs_issued++;
  endtask

  // Random instruction, mostly from the covered forms
  task automatic issue_random_instr();
    logic [15:0] r, ins;
    logic [31:0] a, b, off;
    int          sel;
    r   = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 14) ins = enc_shift(shift_kind_e'($urandom_range(0, 2)), r[10:6], r[5:3], r[2:0]);
    else if (sel < 28) ins = enc_addsub(r[10], r[9], r[8:6], r[5:3], r[2:0]);
    else if (sel < 44) ins = enc_imm(imm_op_e'(r[12:11]), r[10:8], r[7:0]);
    else if (sel < 70) ins = enc_alu(alu_op_e'(r[9:6]), r[5:3], r[2:0]);
    else if (sel < 86) ins = enc_hi(hi_op_e'(r[9:8]), r[7], r[6], r[5:3], r[2:0]);
    else ins = r;
    a   = pick_word();
    b   = pick_word();
    off = pick_word();
    // register shift amounts near the 32-bit boundaries
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0: b[7:0] = 8'd0;
        1: b[7:0] = 8'd31;
        2: b[7:0] = 8'd32;
        3: b[7:0] = 8'd33;
        4: b[7:0] = 8'd64;
        5: b[7:0] = 8'd255;
        6: b[7:0] = 8'd1;
        default: b[7:0] = 8'($urandom);
      endcase
    end
    issue_instr(ins, a, b, off, 4'($urandom));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_shift_imm();
    issue_instr(enc_shift(SHIFT_LSL, 5'd0, 3'd1, 3'd2), '0, 32'h8000_0001, '0, 4'b0010);
    issue_instr(enc_shift(SHIFT_LSR, 5'd0, 3'd7, 3'd0), '0, 32'h8000_0000, '0, 4'b0000);
    issue_instr(enc_shift(SHIFT_ASR, 5'd0, 3'd3, 3'd4), '0, 32'hffff_0000, '0, 4'b0001);
    issue_instr(enc_shift(SHIFT_LSL, 5'd31, 3'd5, 3'd6), '0, 32'hffff_ffff, '0, 4'b1111);
    drain_results();
  endtask

  task automatic test_add_sub();
    issue_instr(enc_addsub(1'b0, 1'b0, 3'd1, 3'd2, 3'd3), '0, 32'h7fff_ffff, 32'd1, 4'b0000);
    issue_instr(enc_addsub(1'b0, 1'b1, 3'd4, 3'd5, 3'd6), '0, 32'd0, 32'd1, 4'b0110);
    issue_instr(enc_addsub(1'b1, 1'b0, 3'd7, 3'd0, 3'd7), '0, 32'hffff_ffff, '1, 4'b1000);
    issue_instr(enc_addsub(1'b1, 1'b1, 3'd0, 3'd6, 3'd1), '0, 32'd0, '1, 4'b0000);
    drain_results();
  endtask

  task automatic test_imm_ops();
    issue_instr(enc_imm(IMM_MOV, 3'd7, 8'hff), 32'hffff_ffff, '0, '0, 4'b0111);
    issue_instr(enc_imm(IMM_CMP, 3'd0, 8'h00), 32'd0, '0, '0, 4'b1000);
    issue_instr(enc_imm(IMM_ADD, 3'd3, 8'hff), 32'hffff_ff01, '0, '0, 4'b0000);
    issue_instr(enc_imm(IMM_SUB, 3'd5, 8'h01), 32'h8000_0000, '0, '0, 4'b0100);
    drain_results();
  endtask

  task automatic test_alu_ops();
    alu_op_e     op;
    logic [31:0] b;
    for (int i = 0; i < 16; i++) begin
      op = alu_op_e'(i);
      // shift ops get amounts of 32 or more, and LSL also junk above bit 7
      case (op)
        ALU_LSL: b = 32'hffff_ff20;
        ALU_LSR: b = 32'h0000_0021;
        ALU_ASR: b = 32'h0000_00ff;
        ALU_ROR: b = 32'h0000_0040;
        default: b = 32'hffff_ffff;
      endcase
      issue_instr(enc_alu(op, 3'(i), 3'(i + 1)), 32'h8000_0001, b, '0, 4'(i));
    end
    drain_results();
  endtask

  task automatic test_hireg_and_uncovered();
    // add into r15: odd sum has bit 0 cleared and the pipeline refills
    issue_instr(enc_hi(HI_ADD, 1'b1, 1'b0, 3'd2, 3'd7), 32'h0000_1001, 32'h0000_0100, '0,
                4'b1010);
    issue_instr(enc_hi(HI_CMP, 1'b1, 1'b1, 3'd4, 3'd3), 32'h8000_0000, 32'd1, '0, 4'b0000);
    // both H bits clear still executes
    issue_instr(enc_hi(HI_MOV, 1'b0, 1'b0, 3'd1, 3'd2), '0, 32'h1234_5679, '0, 4'b0101);
    issue_instr(enc_hi(HI_BX, 1'b0, 1'b1, 3'd6, 3'd0), '1, '1, '1, 4'b1100);
    // long branch halfword, outside the covered forms
    issue_instr(16'hffff, '1, '1, '1, 4'b0011);
    drain_results();
  endtask

  task automatic test_backpressure();
    quiet     = 1'b1;
    hold_left = 80;
    repeat (40) issue_random_instr();
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 1100; i++) begin
      quiet = (i >= 300 && i < 500);
      issue_random_instr();
    end
    quiet = 1'b0;
    drain_results();
  endtask

  // Receiver: random stalls, a counted hold-off on request that wins even when quiet, else none when quiet
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 23);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(negedge clk_i) begin
    tdpu_result_t got, want;
    logic [15:0]  ins;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.value       = result_value_o;
      got.dest        = dest_index_o;
      got.wr_en       = write_enable_o;
      got.flags       = flags_out_o;
      got.pc_reload   = pc_reload_o;
      got.unsupported = unsupported_o;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with nothing outstanding: value=%h dest=%0d", got.value,
                   got.dest);
      end else begin
        want = pending_results.pop_front();
        ins  = pending_instrs.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: instr %h expected value=%h dest=%0d we=%b nzcv=%b pcr=%b uns=%b",
                     ins, want.value, want.dest, want.wr_en, want.flags, want.pc_reload,
                     want.unsupported);
            $display("       got            value=%h dest=%0d we=%b nzcv=%b pcr=%b uns=%b",
                     got.value, got.dest, got.wr_en, got.flags, got.pc_reload,
                     got.unsupported);
          end
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_shift_imm();
    test_add_sub();
    test_imm_ops();
    test_alu_ops();
    test_hireg_and_uncovered();
    test_backpressure();
    test_random_mix();
    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Summary: %0d instructions sent, %0d results checked, %0d mismatches.",
             instrs_issued, results_checked, mismatch_count);
    $display("Covered all forms and ALU ops, shift corners, uncovered encodings, hold-off.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("thumb_data_processing_unit verification clean");
    end else begin
      $display("thumb_data_processing_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("thumb_data_processing_unit verification failed");
    $finish;
  end

endmodule

>>> thumb_data_processing_unit.f
rtl/tdpu_pkg.sv
rtl/tdpu_shifter.sv
rtl/tdpu_exec.sv
rtl/thumb_data_processing_unit.sv
dv/tb.sv
